### hdl/eafr_pkg.sv
package eafr_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;
  localparam logic [7:0] XON_BYTE  = 8'h11;
  localparam logic [7:0] XOFF_BYTE = 8'h13;
  localparam logic [7:0] TYPE_MODEM  = 8'h8A;
  localparam logic [7:0] TYPE_TXSTAT = 8'h8B;
  localparam logic [7:0] TYPE_ATRESP = 8'h88;
  localparam logic [7:0] TYPE_RXPKT  = 8'h90;
  localparam logic [7:0] MODEM_ASSOC    = 8'h02;
  localparam logic [7:0] MODEM_DISASSOC = 8'h03;
  localparam logic [7:0] CSUM_BASE = 8'hFF;

  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_ARM_AT = 2'd1;
  localparam logic [1:0] OP_ARM_TX = 2'd2;
  localparam logic [1:0] OP_ARM_RX = 2'd3;

  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_MODEM   = 3'd1;
  localparam logic [2:0] KIND_TXSTAT  = 3'd2;
  localparam logic [2:0] KIND_AT_DONE = 3'd3;
  localparam logic [2:0] KIND_RX_DONE = 3'd4;

  localparam logic [1:0] DEST_AT   = 2'd0;
  localparam logic [1:0] DEST_REQ  = 2'd1;
  localparam logic [1:0] DEST_HOLD = 2'd2;

  localparam logic [1:0] EXP_NONE   = 2'd0;
  localparam logic [1:0] EXP_TXSTAT = 2'd1;
  localparam logic [1:0] EXP_AT     = 2'd2;

  localparam int HDR_DEPTH = 11;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  rx_byte;
    logic [7:0]  sequence_id;
    logic [15:0] buffer_limit;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_offset;
    logic [1:0]  destination;
    logic [7:0]  status_code;
    logic [15:0] data_count;
    logic [63:0] source_addr_long;
    logic [15:0] source_addr_short;
    logic        is_associated;
  } out_item_t;

endpackage

### hdl/eafr_if.sv
interface eafr_in_if;
  logic                valid;
  logic                ready;
  eafr_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface eafr_out_if;
  logic                valid;
  logic                ready;
  eafr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/eafr_core.sv
module eafr_core #(
  parameter int HOLD_BUFFER_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  eafr_pkg::in_item_t  item,
  output logic                res_valid,
  output eafr_pkg::out_item_t res
);

  localparam logic [3:0] PH_MARK = 4'd0, PH_LEN_HI = 4'd1, PH_LEN_LO = 4'd2,
    PH_TYPE = 4'd3, PH_MODEM = 4'd4, PH_TXSTAT = 4'd5, PH_ATRESP = 4'd6,
    PH_HOLD = 4'd7, PH_REQ = 4'd8;
  localparam logic [15:0] HOLD_LIM = 16'(HOLD_BUFFER_DEPTH);

  logic [3:0]  phase_r, phase_nxt;
  logic        esc_r, esc_nxt, body_r, body_nxt;
  logic [15:0] size_r, size_nxt, pay_r, pay_nxt, rd_r, rd_nxt;
  logic [3:0]  hlen_r, hlen_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  hdr_r [eafr_pkg::HDR_DEPTH];
  logic [1:0]  expk_r, expk_nxt;
  logic [7:0]  expseq_r, expseq_nxt;
  logic [15:0] rlim_r, rlim_nxt, dlim_r, dlim_nxt;
  logic        dreq_r, dreq_nxt, assoc_r, assoc_nxt;
  logic        hdr_we;
  logic [7:0]  b;
  logic [15:0] sz_full, rem, lim_sel;
  logic [16:0] pay_end;
  logic        v;
  eafr_pkg::out_item_t o;

  always_comb begin
    phase_nxt = phase_r; esc_nxt = esc_r; body_nxt = body_r; size_nxt = size_r;
    pay_nxt = pay_r; rd_nxt = rd_r; hlen_nxt = hlen_r; sum_nxt = sum_r;
    expk_nxt = expk_r; expseq_nxt = expseq_r; rlim_nxt = rlim_r; dlim_nxt = dlim_r;
    dreq_nxt = dreq_r; assoc_nxt = assoc_r; hdr_we = 1'b0;
    v = 1'b0; o = '0;
    b = esc_r ? (item.rx_byte ^ eafr_pkg::ESC_XOR) : item.rx_byte;
    sz_full = {size_r[15:8], item.rx_byte};
    pay_end = {13'd0, hlen_r} + {1'b0, pay_r};
    rem = '0; lim_sel = '0;
    unique case (item.op)
      eafr_pkg::OP_ARM_AT: begin
        expk_nxt = eafr_pkg::EXP_AT; expseq_nxt = item.sequence_id;
        rlim_nxt = item.buffer_limit;
      end
      eafr_pkg::OP_ARM_TX: expk_nxt = eafr_pkg::EXP_TXSTAT;
      eafr_pkg::OP_ARM_RX: if (assoc_r) begin
        dlim_nxt = item.buffer_limit; dreq_nxt = 1'b1;
      end
      default: begin
        if (item.rx_byte == eafr_pkg::XON_BYTE || item.rx_byte == eafr_pkg::XOFF_BYTE) begin
        end else if (item.rx_byte == eafr_pkg::FLAG_BYTE) begin
          phase_nxt = PH_LEN_HI; esc_nxt = 1'b0; body_nxt = 1'b0;
        end else if (item.rx_byte == eafr_pkg::ESC_BYTE) begin
          esc_nxt = 1'b1;
        end else begin
          esc_nxt = 1'b0;
          if (body_r) begin
            if (rd_r < {12'd0, hlen_r}) begin
              sum_nxt = sum_r + b; hdr_we = 1'b1; rd_nxt = rd_r + 16'd1;
            end else if ({1'b0, rd_r} < pay_end) begin
              sum_nxt = sum_r + b; rd_nxt = rd_r + 16'd1; v = 1'b1;
              o.kind = eafr_pkg::KIND_PAYLOAD; o.data_byte = b;
              o.byte_offset = rd_r - {12'd0, hlen_r};
              o.destination = (phase_r == PH_ATRESP) ? eafr_pkg::DEST_AT :
                              (phase_r == PH_REQ) ? eafr_pkg::DEST_REQ :
                              eafr_pkg::DEST_HOLD;
            end else if (rd_r < size_r) begin
              sum_nxt = sum_r + b; rd_nxt = rd_r + 16'd1;
            end else begin
              body_nxt = 1'b0; phase_nxt = PH_MARK;
              if (b == eafr_pkg::CSUM_BASE - sum_r) begin
                if (phase_r == PH_MODEM) begin
                  v = 1'b1; o.kind = eafr_pkg::KIND_MODEM; o.status_code = hdr_r[0];
                  if (hdr_r[0] == eafr_pkg::MODEM_ASSOC) assoc_nxt = 1'b1;
                  else if (hdr_r[0] == eafr_pkg::MODEM_DISASSOC) begin
                    assoc_nxt = 1'b0; dreq_nxt = 1'b0;
                  end
                end else if (phase_r == PH_TXSTAT) begin
                  expk_nxt = eafr_pkg::EXP_NONE; v = 1'b1;
                  o.kind = eafr_pkg::KIND_TXSTAT; o.status_code = hdr_r[4];
                end else if (phase_r == PH_ATRESP) begin
                  if (hdr_r[0] == expseq_r) begin
                    expk_nxt = eafr_pkg::EXP_NONE; v = 1'b1;
                    o.kind = eafr_pkg::KIND_AT_DONE; o.status_code = hdr_r[3];
                    o.data_count = pay_r;
                  end
                end else if (phase_r == PH_REQ) begin
                  dreq_nxt = 1'b0; v = 1'b1;
                  o.kind = eafr_pkg::KIND_RX_DONE; o.data_count = pay_r;
                  o.source_addr_long = {hdr_r[0], hdr_r[1], hdr_r[2], hdr_r[3],
                                        hdr_r[4], hdr_r[5], hdr_r[6], hdr_r[7]};
                  o.source_addr_short = {hdr_r[8], hdr_r[9]};
                end
              end
            end
          end else begin
            unique case (phase_r)
              PH_LEN_HI: begin size_nxt = {b, 8'd0}; phase_nxt = PH_LEN_LO; end
              PH_LEN_LO: begin
                sz_full = {size_r[15:8], b};
                if (sz_full == 16'd0) phase_nxt = PH_MARK;
                else begin size_nxt = sz_full - 16'd1; phase_nxt = PH_TYPE; end
              end
              PH_TYPE: begin
                phase_nxt = PH_MARK;
                rd_nxt = rd_r; 
                case (b)
                  eafr_pkg::TYPE_MODEM: if (size_r >= 16'd1) begin
                    hlen_nxt = 4'd1; pay_nxt = '0; phase_nxt = PH_MODEM;
                  end
                  eafr_pkg::TYPE_TXSTAT:
                    if (size_r >= 16'd6 && expk_r == eafr_pkg::EXP_TXSTAT) begin
                      hlen_nxt = 4'd6; pay_nxt = '0; phase_nxt = PH_TXSTAT;
                    end
                  eafr_pkg::TYPE_ATRESP:
                    if (size_r >= 16'd4 && expk_r == eafr_pkg::EXP_AT) begin
                      rem = size_r - 16'd4; hlen_nxt = 4'd4;
                      pay_nxt = (rem > rlim_r) ? rlim_r : rem; phase_nxt = PH_ATRESP;
                    end
                  eafr_pkg::TYPE_RXPKT: if (size_r >= 16'd11) begin
                    rem = size_r - 16'd11; hlen_nxt = 4'd11;
                    lim_sel = dreq_r ? dlim_r : HOLD_LIM;
                    pay_nxt = (rem > lim_sel) ? lim_sel : rem;
                    phase_nxt = dreq_r ? PH_REQ : PH_HOLD;
                  end
                  default: phase_nxt = PH_MARK;
                endcase
                if (phase_nxt != PH_MARK) begin
                  rd_nxt = '0; sum_nxt = b; body_nxt = 1'b1;
                end
              end
              default: phase_nxt = PH_MARK;
            endcase
          end
        end
      end
    endcase
    o.is_associated = assoc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MARK; esc_r <= 1'b0; body_r <= 1'b0; size_r <= '0;
      pay_r <= '0; rd_r <= '0; hlen_r <= '0; sum_r <= '0;
      expk_r <= eafr_pkg::EXP_NONE; expseq_r <= 8'hFF; rlim_r <= '0;
      dlim_r <= '0; dreq_r <= 1'b0; assoc_r <= 1'b0; res_valid <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt; esc_r <= esc_nxt; body_r <= body_nxt;
      size_r <= size_nxt; pay_r <= pay_nxt; rd_r <= rd_nxt; hlen_r <= hlen_nxt;
      sum_r <= sum_nxt; expk_r <= expk_nxt; expseq_r <= expseq_nxt;
      rlim_r <= rlim_nxt; dlim_r <= dlim_nxt; dreq_r <= dreq_nxt;
      assoc_r <= assoc_nxt; res_valid <= v;
    end else begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res <= o;
    if (step && hdr_we && rd_r < 16'(eafr_pkg::HDR_DEPTH))
      hdr_r[rd_r[3:0]] <= b;
  end

endmodule

### hdl/eafr_outbuf.sv
module eafr_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  eafr_pkg::out_item_t res,
  output logic                can_take,
  eafr_out_if.source          out_ch
);

  // two-entry skid: main output register plus spare
  logic                main_v_r, skid_v_r;
  eafr_pkg::out_item_t main_r, skid_r;

  assign can_take = !skid_v_r;
  assign out_ch.valid = main_v_r;
  assign out_ch.data = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0; skid_v_r <= 1'b0;
    end else begin
      if (!main_v_r || out_ch.ready) begin
        if (skid_v_r) begin
          main_v_r <= 1'b1; main_r <= skid_r;
          skid_v_r <= res_valid; skid_r <= res;
        end else begin
          main_v_r <= res_valid; main_r <= res;
        end
      end else if (res_valid) begin
        skid_v_r <= 1'b1; skid_r <= res;
      end
    end
  end

endmodule

### hdl/escaped_api_frame_receiver.sv
// a result beat is registered first in the core and then in the output stage before it appears on out_ch
// throughput: one input beat per cycle while in_ch.ready is high; each beat is decoded in a single pass
// a two-entry output stage lets input continue while one result waits
// reset: synchronous active-low rst_n returns the deframer to waiting for a flag
module escaped_api_frame_receiver #(
  parameter int HOLD_BUFFER_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  eafr_in_if.sink    in_ch,
  eafr_out_if.source out_ch
);

  logic                step, res_valid, can_take;
  eafr_pkg::out_item_t res;

  // take a beat only when the spare slot is free and no waiting result is about to fill it, so no result is lost
  assign in_ch.ready = can_take && !(res_valid && out_ch.valid && !out_ch.ready);
  assign step = in_ch.valid && in_ch.ready;

  eafr_core #(.HOLD_BUFFER_DEPTH(HOLD_BUFFER_DEPTH)) u_core (
    .clk, .rst_n, .step, .item(in_ch.data), .res_valid, .res
  );

  eafr_outbuf u_buf (
    .clk, .rst_n, .res_valid, .res, .can_take, .out_ch
  );

endmodule

### hdl/eafr_checker.sv
module eafr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] out_kind,
  input logic [1:0] out_dest
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid) else $error("input beat withdrawn");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= eafr_pkg::KIND_RX_DONE) else $error("bad kind");
  a_dest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dest != 2'd3) else $error("bad destination");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");

endmodule

bind escaped_api_frame_receiver eafr_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_kind(out_ch.data.kind), .out_dest(out_ch.data.destination)
);
